### rtl/nstp_pkg.sv
package nstp_pkg;

   localparam int TIME_W           = 64;
   localparam int REGION_INDEX_W   = 10;
   localparam int MODE_W           = 2;
   localparam int STATUS_W         = 2;

   localparam int REGION_COUNT_DEF = 1024;
   localparam int STACK_DEPTH_DEF  = 256;

   localparam logic [MODE_W-1:0] MODE_ENTER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXIT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [REGION_INDEX_W-1:0] region_index;
      logic [TIME_W-1:0]         timestamp;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TIME_W-1:0]   total_time;
      logic [TIME_W-1:0]   own_time;
      logic [TIME_W-1:0]   shortest_time;
      logic [TIME_W-1:0]   longest_time;
      logic [TIME_W-1:0]   calls;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic reduce;
      logic lookup;
      logic diff;
      logic update;
      logic commit;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic exit_ok;
      logic out_free;
   } status_type;

endpackage

### rtl/nstp_ctrl.sv
module nstp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nstp_pkg::status_type status,
   output nstp_pkg::cmd_type    cmd
);
   import nstp_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_REDUCE = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_DIFF   = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;
   localparam logic [2:0] ST_COMMIT = 3'd6;
   localparam logic [2:0] ST_RESP   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = status.exit_ok ? ST_DIFF : ST_COMMIT;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/nstp_dpath.sv
module nstp_dpath #(
   parameter int REGION_COUNT = nstp_pkg::REGION_COUNT_DEF,
   parameter int STACK_DEPTH  = nstp_pkg::STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nstp_pkg::cmd_type    cmd,
   output nstp_pkg::status_type status,
   input  nstp_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nstp_pkg::rsp_type    rsp_data
);
   import nstp_pkg::*;

   localparam int R_W       = $clog2(REGION_COUNT);
   localparam int RC_W      = $clog2(REGION_COUNT + 1);
   localparam int IDX_W     = $clog2(STACK_DEPTH);
   localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
   localparam int RED_SHIFT = REGION_INDEX_W + $clog2(REGION_COUNT);
   localparam int MUL_W     = REGION_INDEX_W + 2;
   localparam int PROD_W    = REGION_INDEX_W + MUL_W;
   localparam int REM_W     = REGION_INDEX_W + RC_W;
   localparam longint unsigned RED_MUL =
      ((64'd1 << RED_SHIFT) + 64'(REGION_COUNT) - 64'd1) / 64'(REGION_COUNT);

   typedef struct packed {
      logic [TIME_W-1:0] sum_elapsed;
      logic [TIME_W-1:0] sum_self;
      logic [TIME_W-1:0] min_elapsed;
      logic [TIME_W-1:0] max_elapsed;
      logic [TIME_W-1:0] exit_count;
   } stats_type;

   localparam stats_type STATS_INIT = '{
      sum_elapsed: '0, sum_self: '0, min_elapsed: '1, max_elapsed: '0, exit_count: '0};

   stats_type                 stat_mem [REGION_COUNT];
   logic [R_W-1:0]            frame_region_mem [STACK_DEPTH];
   logic [TIME_W-1:0]         frame_entry_mem  [STACK_DEPTH];
   logic [TIME_W-1:0]         frame_child_mem  [STACK_DEPTH];

   logic [MODE_W-1:0]         mode_ff;
   logic [REGION_INDEX_W-1:0] index_ff;
   logic [TIME_W-1:0]         ts_ff;
   logic [REGION_INDEX_W-1:0] quot_ff;
   logic [REGION_INDEX_W-1:0] quot_in;
   logic [PROD_W-1:0]         prod;
   logic [REM_W-1:0]          rem_full;
   logic [R_W-1:0]            region_ff;

   logic [R_W-1:0]            clr_ptr_ff;
   logic [LVL_W-1:0]          level_ff;
   logic [LVL_W-1:0]          level_in;
   logic [LVL_W-1:0]          lvl_dec1;
   logic [LVL_W-1:0]          lvl_dec2;
   logic [IDX_W-1:0]          top_idx;
   logic [IDX_W-1:0]          par_idx;
   logic [IDX_W-1:0]          push_idx;
   logic                      full;
   logic                      empty;
   logic                      exit_ok;
   logic                      push;

   logic [R_W-1:0]            region_rd_ff;
   logic [TIME_W-1:0]         entry_rd_ff;
   logic [TIME_W-1:0]         child_top_rd_ff;
   logic [TIME_W-1:0]         child_par_rd_ff;
   stats_type                 stat_rd_ff;

   logic [TIME_W-1:0]         elapsed_ff;
   logic [TIME_W-1:0]         self_ff;
   logic [TIME_W-1:0]         par_child_ff;
   stats_type                 part_ff;
   stats_type                 upd;

   logic                      stat_we;
   logic [R_W-1:0]            stat_waddr;
   stats_type                 stat_wdata;
   logic                      child_we;
   logic [IDX_W-1:0]          child_waddr;
   logic [TIME_W-1:0]         child_wdata;

   rsp_type                   res_ff;
   rsp_type                   res_in;
   rsp_type                   rsp_data_ff;
   logic                      rsp_valid_ff;

   // region reduction: reciprocal multiply, then remainder
   assign prod     = PROD_W'(req_data.region_index) * PROD_W'(RED_MUL[MUL_W-1:0]);
   assign quot_in  = REGION_INDEX_W'(prod >> RED_SHIFT);
   assign rem_full = REM_W'(index_ff) - REM_W'(quot_ff) * REM_W'(REGION_COUNT);

   assign full     = (level_ff == LVL_W'(STACK_DEPTH));
   assign empty    = (level_ff <= LVL_W'(1));
   assign exit_ok  = (mode_ff == MODE_EXIT) && !empty;
   assign push     = (mode_ff == MODE_ENTER) && !full;
   assign lvl_dec1 = level_ff - LVL_W'(1);
   assign lvl_dec2 = level_ff - LVL_W'(2);
   assign top_idx  = lvl_dec1[IDX_W-1:0];
   assign par_idx  = lvl_dec2[IDX_W-1:0];
   assign push_idx = level_ff[IDX_W-1:0];

   assign status.clear_last = (clr_ptr_ff == R_W'(REGION_COUNT - 1));
   assign status.exit_ok    = exit_ok;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_data.mode;
         index_ff <= req_data.region_index;
         ts_ff    <= req_data.timestamp;
         quot_ff  <= quot_in;
      end
      if (cmd.reduce) begin
         region_ff <= rem_full[R_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         level_ff   <= LVL_W'(1);
      end else begin
         if (cmd.clear) begin
            clr_ptr_ff <= clr_ptr_ff + R_W'(1);
         end
         level_ff <= level_in;
      end
   end

   always_comb begin
      level_in = level_ff;
      if (cmd.commit && push) begin
         level_in = level_ff + LVL_W'(1);
      end else if (cmd.commit && exit_ok) begin
         level_in = lvl_dec1;
      end
   end

   // statistics store
   assign stat_we    = cmd.clear || (cmd.commit && exit_ok);
   assign stat_waddr = cmd.clear ? clr_ptr_ff : region_ff;
   assign stat_wdata = cmd.clear ? STATS_INIT : upd;

   always_ff @(posedge clock) begin
      if (stat_we) begin
         stat_mem[stat_waddr] <= stat_wdata;
      end
      if (cmd.lookup) begin
         stat_rd_ff <= stat_mem[region_ff];
      end
   end

   // frame stack
   assign child_we    = cmd.commit && (push || exit_ok);
   assign child_waddr = push ? push_idx : par_idx;
   assign child_wdata = push ? '0 : par_child_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit && push) begin
         frame_region_mem[push_idx] <= region_ff;
         frame_entry_mem[push_idx]  <= ts_ff;
      end
      if (child_we) begin
         frame_child_mem[child_waddr] <= child_wdata;
      end
      if (cmd.lookup) begin
         region_rd_ff    <= frame_region_mem[top_idx];
         entry_rd_ff     <= frame_entry_mem[top_idx];
         child_top_rd_ff <= frame_child_mem[top_idx];
         child_par_rd_ff <= frame_child_mem[par_idx];
      end
   end

   // exit arithmetic
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         elapsed_ff <= ts_ff - entry_rd_ff;
      end
      if (cmd.update) begin
         self_ff              <= elapsed_ff - child_top_rd_ff;
         par_child_ff         <= child_par_rd_ff + elapsed_ff;
         part_ff.sum_elapsed  <= stat_rd_ff.sum_elapsed + elapsed_ff;
         part_ff.sum_self     <= stat_rd_ff.sum_self;
         part_ff.exit_count   <= stat_rd_ff.exit_count + TIME_W'(1);
         part_ff.min_elapsed  <= (elapsed_ff < stat_rd_ff.min_elapsed) ?
                                 elapsed_ff : stat_rd_ff.min_elapsed;
         part_ff.max_elapsed  <= (elapsed_ff > stat_rd_ff.max_elapsed) ?
                                 elapsed_ff : stat_rd_ff.max_elapsed;
      end
   end

   always_comb begin
      upd          = part_ff;
      upd.sum_self = part_ff.sum_self + self_ff;
   end

   always_comb begin
      res_in = '0;
      case (mode_ff)
         MODE_ENTER: begin
            res_in.status = full ? STATUS_FULL : STATUS_OK;
         end
         MODE_EXIT: begin
            if (empty) begin
               res_in.status = STATUS_EMPTY;
            end else begin
               res_in.status        = (region_rd_ff != region_ff) ? STATUS_MISMATCH :
                                      STATUS_OK;
               res_in.total_time    = upd.sum_elapsed;
               res_in.own_time      = upd.sum_self;
               res_in.shortest_time = upd.min_elapsed;
               res_in.longest_time  = upd.max_elapsed;
               res_in.calls         = upd.exit_count;
            end
         end
         MODE_READ: begin
            res_in.status        = STATUS_OK;
            res_in.total_time    = stat_rd_ff.sum_elapsed;
            res_in.own_time      = stat_rd_ff.sum_self;
            res_in.shortest_time = stat_rd_ff.min_elapsed;
            res_in.longest_time  = stat_rd_ff.max_elapsed;
            res_in.calls         = stat_rd_ff.exit_count;
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_ff <= res_in;
      end
      if (cmd.respond) begin
         rsp_data_ff <= res_ff;
      end
   end

   // hold the word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (level_ff >= LVL_W'(1)) && (level_ff <= LVL_W'(STACK_DEPTH)))
      else $error("stack level out of range");

   a_level_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(level_ff))
      else $error("stack level moved outside commit");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && exit_ok) |=> (level_ff == $past(lvl_dec1)))
      else $error("exit did not pop one frame");

   a_respond_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

endmodule

### rtl/nested_scope_time_profiler.sv
// Nested scope time profiler. Each request word is an enter, exit or read event for a code
// region with a 64-bit timestamp; every request gives exactly one response word with a status,
// and non-empty exit and read responses also carry the region's statistics (total, self,
// minimum and maximum elapsed time, exit count). Requests are processed one at a time by a
// controller that steps a datapath through frame-stack and statistics memories. Each request
// passes address reduction and a memory read before its result is committed; an exit adds
// separate subtract and accumulate steps on 64-bit values. The next request is taken in the
// cycle after the response is loaded, so a new request is not accepted until the last one is
// answered. A response that is not yet taken holds the next request in its final step.
// After reset the statistics memory is swept once, one region per cycle, while req_ready is low.
module nested_scope_time_profiler #(
   parameter int REGION_COUNT = nstp_pkg::REGION_COUNT_DEF,
   parameter int STACK_DEPTH  = nstp_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nstp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nstp_pkg::rsp_type rsp_data
);
   import nstp_pkg::*;

   cmd_type    cmd;
   status_type status;

   nstp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nstp_dpath #(
      .REGION_COUNT (REGION_COUNT),
      .STACK_DEPTH  (STACK_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
